FILE: rtl/core/aes_cbc_pkg.sv
package aes_cbc_pkg;

   typedef struct packed {
      logic [63:0] block_hi;
      logic [63:0] block_lo;
      logic [4:0]  byte_count;
      logic        last_block;
   } req_payload_type;

   typedef struct packed {
      logic [63:0] out_hi;
      logic [63:0] out_lo;
      logic [4:0]  out_count;
      logic        out_last;
   } rsp_payload_type;

   localparam logic [2:0] REG_KEY0 = 3'd0;
   localparam logic [2:0] REG_KEY1 = 3'd1;
   localparam logic [2:0] REG_KEY2 = 3'd2;
   localparam logic [2:0] REG_KEY3 = 3'd3;
   localparam logic [2:0] REG_KSIZE = 3'd4;
   localparam logic [2:0] REG_DIR = 3'd5;
   localparam logic [2:0] REG_IVHI = 3'd6;
   localparam logic [2:0] REG_IVLO = 3'd7;

   localparam logic [1:0] KSIZE_128 = 2'd0;
   localparam logic [1:0] KSIZE_192 = 2'd1;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] ISBOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   function automatic logic [7:0] xt(input logic [7:0] a);
      xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

   // forward round without key add: sub bytes, shift rows, optional mix columns
   function automatic logic [127:0] enc_round(input logic [127:0] s, input logic mix);
      logic [7:0] b [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3;
      logic [127:0] r;
      for (int i = 0; i < 16; i++) b[i] = SBOX[s[127-8*i -: 8]];
      for (int rr = 0; rr < 4; rr++)
         for (int c = 0; c < 4; c++) t[rr+4*c] = b[rr+4*((c+rr)%4)];
      if (mix) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            t[4*c]   = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
            t[4*c+1] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
            t[4*c+2] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
            t[4*c+3] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
         end
      end
      for (int i = 0; i < 16; i++) r[127-8*i -: 8] = t[i];
      enc_round = r;
   endfunction

   function automatic logic [127:0] inv_mix(input logic [127:0] s);
      logic [7:0] a [4];
      logic [7:0] x2 [4];
      logic [7:0] x4 [4];
      logic [7:0] x8 [4];
      logic [127:0] r;
      for (int c = 0; c < 4; c++) begin
         for (int k = 0; k < 4; k++) begin
            a[k] = s[127-8*(4*c+k) -: 8];
            x2[k] = xt(a[k]); x4[k] = xt(x2[k]); x8[k] = xt(x4[k]);
         end
         for (int k = 0; k < 4; k++)
            r[127-8*(4*c+k) -: 8] =
               (x8[k] ^ x4[k] ^ x2[k]) ^
               (x8[(k+1)%4] ^ x2[(k+1)%4] ^ a[(k+1)%4]) ^
               (x8[(k+2)%4] ^ x4[(k+2)%4] ^ a[(k+2)%4]) ^
               (x8[(k+3)%4] ^ a[(k+3)%4]);
      end
      inv_mix = r;
   endfunction

   // inverse shift rows and inverse sub bytes
   function automatic logic [127:0] dec_sub(input logic [127:0] s);
      logic [7:0] b [16];
      logic [127:0] r;
      for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
      for (int rr = 0; rr < 4; rr++)
         for (int c = 0; c < 4; c++)
            r[127-8*(rr+4*c) -: 8] = ISBOX[b[rr+4*((c+4-rr)%4)]];
      dec_sub = r;
   endfunction

endpackage

FILE: rtl/core/aes_cbc_pkcs7_engine.sv
// AES-CBC engine with PKCS7 padding, 128/192/256-bit keys. One block is taken at a time; req_ready
// is low while a block is in flight or a result waits. A round is one pass through a shared round
// unit. Its 128-bit round key is read from a word RAM with registered read, one word per cycle,
// in the key read state, then the round is applied in the round state. The result register is
// loaded in the last round and raised valid in the output state. A full final encrypt block
// runs the cipher a second time for the padding block once the first result has been taken.
// After a key or key size write the next transaction first expands the schedule, one word per
// cycle, writing 4*(Nk+7) words.
module aes_cbc_pkcs7_engine #(
   parameter int ROUND_KEY_WORDS = 60
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  aes_cbc_pkg::req_payload_type      req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output aes_cbc_pkg::rsp_payload_type      rsp_payload,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [5:0]                        paddr,
   input  logic [63:0]                       pwdata,
   output logic [63:0]                       prdata,
   output logic                              pready
);
   localparam int AW = $clog2(ROUND_KEY_WORDS);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_EXP   = 7'b0000010,
      S_KRD   = 7'b0000100,
      S_RND   = 7'b0001000,
      S_OUT   = 7'b0010000,
      S_PAD   = 7'b0100000,
      S_EXPRD = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [63:0] key_ff [4];
   logic [1:0]  ksize_ff;
   logic        dir_ff;
   logic [63:0] iv_hi_ff, iv_lo_ff;
   logic [127:0] chain_ff;
   logic        keys_ready_ff;

   logic [127:0] st_ff;
   logic [127:0] rk_ff;
   logic [3:0]  round_ff;
   logic [2:0]  kw_ff;
   logic [AW:0] widx_ff;
   logic [3:0]  nkc_ff;      // index mod nk
   logic [7:0]  rcon_ff;
   logic [31:0] prev_ff;
   logic [255:0] kwin_ff;    // last nk words, newest at low end
   logic        last_ff, pad_pend_ff;
   aes_cbc_pkg::rsp_payload_type rsp_ff;
   logic        rsp_valid_ff;

   // effective key length
   logic [3:0] nk, nr;
   always_comb begin
      nk = (ksize_ff == aes_cbc_pkg::KSIZE_128) ? 4'd4 :
           (ksize_ff == aes_cbc_pkg::KSIZE_192) ? 4'd6 : 4'd8;
      if (nk == 4'd8 && 4 * (8 + 7) > ROUND_KEY_WORDS) nk = 4'd6;
      if (nk == 4'd6 && 4 * (6 + 7) > ROUND_KEY_WORDS) nk = 4'd4;
      nr = nk + 4'd6;
   end
   logic [AW:0] total;
   assign total = (AW+1)'(({2'b0, nk} + 6'd7) << 2);

   // ram
   logic           ram_we;
   logic [AW-1:0]  ram_wa, ram_ra;
   logic [31:0]    ram_wd, ram_rd;
   aes_cbc_ram #(.WIDTH(32), .DEPTH(ROUND_KEY_WORDS)) u_ram (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
      .rd_addr(ram_ra), .rd_data(ram_rd)
   );

   // key expansion word
   logic [31:0] kin_w, old_w, t_w, new_w;
   always_comb begin
      kin_w = widx_ff[0] ? key_ff[widx_ff[2:1]][31:0] : key_ff[widx_ff[2:1]][63:32];
      old_w = kwin_ff[32*nk-1 -: 32];
      t_w = prev_ff;
      if (nkc_ff == 4'd0)
         t_w = aes_cbc_pkg::sub_word({prev_ff[23:0], prev_ff[31:24]}) ^ {rcon_ff, 24'h0};
      else if (nk == 4'd8 && nkc_ff == 4'd4)
         t_w = aes_cbc_pkg::sub_word(prev_ff);
      new_w = (widx_ff < (AW+1)'(nk)) ? kin_w : (old_w ^ t_w);
   end

   // round key address
   logic [3:0] rk_round;
   assign rk_round = dir_ff ? (nr - round_ff) : round_ff;
   logic [5:0] rk_addr;
   assign rk_addr = {rk_round, kw_ff[1:0]};

   assign ram_we = (state_ff == S_EXP);
   assign ram_wa = widx_ff[AW-1:0];
   assign ram_wd = new_w;
   assign ram_ra = AW'(rk_addr);

   logic [127:0] round_out, dsub;
   always_comb begin
      dsub = aes_cbc_pkg::dec_sub(st_ff) ^ rk_ff;
      if (dir_ff)
         round_out = (round_ff == 4'd0) ? (st_ff ^ rk_ff) :
                     (round_ff == nr) ? dsub : aes_cbc_pkg::inv_mix(dsub);
      else
         round_out = (round_ff == 4'd0) ? (st_ff ^ rk_ff) :
                     (aes_cbc_pkg::enc_round(st_ff, round_ff != nr) ^ rk_ff);
   end

   // input block after padding; chaining is applied when the block is taken
   logic [4:0] cnt_c;
   logic [127:0] padded;
   always_comb begin
      cnt_c = (req_payload.byte_count > 5'd16) ? 5'd16 : req_payload.byte_count;
      padded = {req_payload.block_hi, req_payload.block_lo};
      if (!dir_ff && req_payload.last_block && cnt_c < 5'd16)
         for (int i = 0; i < 16; i++)
            if (5'(i) >= cnt_c) padded[127-8*i -: 8] = 8'(5'd16 - cnt_c);
   end

   // decrypt final count
   logic [127:0] dec_res, dec_masked;
   logic [4:0]   dec_cnt;
   always_comb begin
      dec_res = round_out ^ chain_ff;
      dec_cnt = (dec_res[3:0] == 4'd0) ? 5'd0 : (5'd16 - {1'b0, dec_res[3:0]});
      dec_masked = dec_res;
      for (int i = 0; i < 16; i++)
         if (5'(i) >= dec_cnt) dec_masked[127-8*i -: 8] = 8'h00;
   end

   logic req_acc, rsp_free, cfg_wr;
   assign req_acc = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign cfg_wr = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_acc) state_in = keys_ready_ff ? S_KRD : S_EXP;
         S_EXP:   if (widx_ff + 1'b1 == total) state_in = S_EXPRD;
         S_EXPRD: state_in = S_KRD;
         S_KRD:   if (kw_ff == 3'd4) state_in = S_RND;
         S_RND:   state_in = (round_ff == nr) ? S_OUT : S_KRD;
         S_OUT:   if (rsp_free) state_in = pad_pend_ff ? S_PAD : S_IDLE;
         S_PAD:   if (rsp_free) state_in = S_KRD;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
         ksize_ff <= '0; dir_ff <= 1'b0; iv_hi_ff <= '0; iv_lo_ff <= '0;
         chain_ff <= '0; keys_ready_ff <= 1'b0; rsp_valid_ff <= 1'b0;
         pad_pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         if (cfg_wr) begin
            unique case (paddr[5:3]) inside
               aes_cbc_pkg::REG_KEY0, aes_cbc_pkg::REG_KEY1,
               aes_cbc_pkg::REG_KEY2, aes_cbc_pkg::REG_KEY3: begin
                  key_ff[paddr[4:3]] <= pwdata; keys_ready_ff <= 1'b0;
               end
               aes_cbc_pkg::REG_KSIZE: begin
                  ksize_ff <= pwdata[1:0]; keys_ready_ff <= 1'b0;
               end
               aes_cbc_pkg::REG_DIR:  dir_ff <= pwdata[0];
               aes_cbc_pkg::REG_IVHI: begin
                  iv_hi_ff <= pwdata; chain_ff[127:64] <= pwdata;
               end
               aes_cbc_pkg::REG_IVLO: begin
                  iv_lo_ff <= pwdata; chain_ff[63:0] <= pwdata;
               end
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: if (req_acc) begin
               st_ff <= dir_ff ? padded : (padded ^ chain_ff);
               last_ff <= req_payload.last_block;
               pad_pend_ff <= !dir_ff && req_payload.last_block && cnt_c == 5'd16;
               round_ff <= '0; kw_ff <= '0;
               widx_ff <= '0; nkc_ff <= '0; rcon_ff <= 8'h01;
               // ciphertext held in the result register for decrypt chaining
               rsp_ff.out_hi <= padded[127:64]; rsp_ff.out_lo <= padded[63:0];
            end
            S_EXP: begin
               widx_ff <= widx_ff + 1'b1;
               prev_ff <= new_w;
               kwin_ff <= {kwin_ff[223:0], new_w};
               if (widx_ff >= (AW+1)'(nk) && nkc_ff == 4'd0) rcon_ff <= aes_cbc_pkg::xt(rcon_ff);
               nkc_ff <= (nkc_ff + 1'b1 == nk) ? 4'd0 : nkc_ff + 1'b1;
            end
            S_EXPRD: keys_ready_ff <= 1'b1;
            S_KRD: begin
               kw_ff <= kw_ff + 1'b1;
               if (kw_ff != 3'd0) rk_ff <= {rk_ff[95:0], ram_rd};
            end
            S_RND: begin
               kw_ff <= '0;
               round_ff <= round_ff + 1'b1;
               st_ff <= round_out;
               if (round_ff == nr) begin
                  if (dir_ff) begin
                     chain_ff <= last_ff ? {iv_hi_ff, iv_lo_ff} :
                                 {rsp_ff.out_hi, rsp_ff.out_lo};
                     {rsp_ff.out_hi, rsp_ff.out_lo} <= last_ff ? dec_masked : dec_res;
                     rsp_ff.out_count <= last_ff ? dec_cnt : 5'd16;
                     rsp_ff.out_last <= last_ff;
                  end else begin
                     chain_ff <= (last_ff && !pad_pend_ff) ? {iv_hi_ff, iv_lo_ff} : round_out;
                     {rsp_ff.out_hi, rsp_ff.out_lo} <= round_out;
                     rsp_ff.out_count <= 5'd16;
                     rsp_ff.out_last <= last_ff && !pad_pend_ff;
                  end
               end
            end
            S_OUT: if (rsp_free) rsp_valid_ff <= 1'b1;
            S_PAD: if (rsp_free) begin
               st_ff <= {16{8'h10}} ^ chain_ff;
               pad_pend_ff <= 1'b0;
               round_ff <= '0; kw_ff <= '0;
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      unique case (paddr[5:3]) inside
         aes_cbc_pkg::REG_KEY0, aes_cbc_pkg::REG_KEY1,
         aes_cbc_pkg::REG_KEY2, aes_cbc_pkg::REG_KEY3: prdata = key_ff[paddr[4:3]];
         aes_cbc_pkg::REG_KSIZE: prdata = {62'h0, ksize_ff};
         aes_cbc_pkg::REG_DIR:   prdata = {63'h0, dir_ff};
         aes_cbc_pkg::REG_IVHI:  prdata = iv_hi_ff;
         aes_cbc_pkg::REG_IVLO:  prdata = iv_lo_ff;
         default: prdata = '0;
      endcase
   end
endmodule

FILE: rtl/core/aes_cbc_ram.sv
module aes_cbc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: rtl/core/aes_cbc_checker.sv
module aes_cbc_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input aes_cbc_pkg::rsp_payload_type rsp_payload,
   input logic                         pready
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after a transaction");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken while a result waits");
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.out_count <= 5'd16)
      else $error("count out of range");
   a_pready: assert property (@(posedge clock) pready)
      else $error("pready low");
endmodule

bind aes_cbc_pkcs7_engine aes_cbc_checker u_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload), .pready(pready)
);

FILE: test/aes_cbc_pkcs7_checker.sv
`timescale 1ns / 1ps

module aes_cbc_pkcs7_checker
   import aes_cbc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  req_payload_type req_payload,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  rsp_payload_type rsp_payload,
   input  logic            psel,
   input  logic            penable,
   input  logic            pwrite,
   input  logic [5:0]      paddr,
   input  logic [63:0]     pwdata,
   input  logic            pready,
   output int              fail_count,
   output int              blocks_owed
);

   logic [63:0]     key_word [4];
   logic [1:0]      key_size;
   logic            decrypt_mode;
   logic [63:0]     iv_hi;
   logic [63:0]     iv_lo;
   logic [127:0]    cbc_chain;
   logic [31:0]     round_key [60];
   logic            keys_expanded;
   int              mismatches;
   rsp_payload_type expected_blocks [$];

   function automatic logic [7:0] times2(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      logic [7:0] x;
      p = 8'h00;
      x = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p = p ^ x;
         x = times2(x);
      end
      return p;
   endfunction

   function automatic int rounds_for_size();
      return (key_size == KSIZE_128) ? 10 : (key_size == KSIZE_192) ? 12 : 14;
   endfunction

   function automatic void expand_schedule();
      int nk;
      logic [31:0] t;
      logic [7:0] rcon;
      nk = rounds_for_size() - 6;
      rcon = 8'h01;
      for (int i = 0; i < 4 * (nk + 7); i++) begin
         if (i < nk) begin
            round_key[i] = i[0] ? key_word[i / 2][31:0] : key_word[i / 2][63:32];
         end else begin
            t = round_key[i - 1];
            if (i % nk == 0) begin
               t = {t[23:0], t[31:24]};
               t = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
               t = t ^ {rcon, 24'h0};
               rcon = times2(rcon);
            end else if (nk > 6 && i % nk == 4) begin
               t = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
            end
            round_key[i] = round_key[i - nk] ^ t;
         end
      end
      keys_expanded = 1'b1;
   endfunction

   function automatic logic [127:0] key_for_round(input int r);
      return {round_key[4*r], round_key[4*r+1], round_key[4*r+2], round_key[4*r+3]};
   endfunction

   // one column mix; forward and inverse differ only in coefficients
   function automatic logic [127:0] mix_state(input logic [127:0] s, input logic inverse);
      logic [7:0] a [4];
      logic [7:0] m [4];
      logic [127:0] r;
      m[0] = inverse ? 8'd14 : 8'd2;
      m[1] = inverse ? 8'd11 : 8'd3;
      m[2] = inverse ? 8'd13 : 8'd1;
      m[3] = inverse ? 8'd9 : 8'd1;
      for (int c = 0; c < 4; c++) begin
         for (int k = 0; k < 4; k++) a[k] = s[127-8*(4*c+k) -: 8];
         for (int k = 0; k < 4; k++)
            r[127-8*(4*c+k) -: 8] = gf_mul(a[k], m[0]) ^ gf_mul(a[(k+1)%4], m[1]) ^
                                    gf_mul(a[(k+2)%4], m[2]) ^ gf_mul(a[(k+3)%4], m[3]);
      end
      return r;
   endfunction

   function automatic logic [127:0] shift_sub(input logic [127:0] s, input logic inverse);
      logic [7:0] b [16];
      logic [7:0] v;
      logic [127:0] r;
      for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
      for (int row = 0; row < 4; row++)
         for (int c = 0; c < 4; c++) begin
            v = b[row + 4 * (inverse ? (c + 4 - row) % 4 : (c + row) % 4)];
            r[127-8*(row+4*c) -: 8] = inverse ? ISBOX[v] : SBOX[v];
         end
      return r;
   endfunction

   function automatic logic [127:0] encipher(input logic [127:0] s);
      int nr;
      logic [127:0] x;
      nr = rounds_for_size();
      x = s ^ key_for_round(0);
      for (int r = 1; r <= nr; r++) begin
         x = shift_sub(x, 1'b0);
         if (r < nr) x = mix_state(x, 1'b0);
         x = x ^ key_for_round(r);
      end
      return x;
   endfunction

   function automatic logic [127:0] decipher(input logic [127:0] s);
      int nr;
      logic [127:0] x;
      nr = rounds_for_size();
      x = s ^ key_for_round(nr);
      for (int r = nr - 1; r >= 0; r--) begin
         x = shift_sub(x, 1'b1);
         x = x ^ key_for_round(r);
         if (r > 0) x = mix_state(x, 1'b1);
      end
      return x;
   endfunction

   function automatic void predict_block(input req_payload_type p);
      int cnt;
      int pad;
      int keep;
      logic [127:0] b;
      logic [127:0] ct;
      cnt = (p.byte_count > 16) ? 16 : int'(p.byte_count);
      if (!keys_expanded) expand_schedule();
      b = {p.block_hi, p.block_lo};
      if (!decrypt_mode) begin
         if (p.last_block && cnt < 16)
            for (int i = cnt; i < 16; i++) b[127-8*i -: 8] = 8'(16 - cnt);
         b = encipher(b ^ cbc_chain);
         cbc_chain = b;
         if (p.last_block && cnt == 16) begin
            expected_blocks.push_back(rsp_payload_type'{b[127:64], b[63:0], 5'd16, 1'b0});
            b = encipher({16{8'h10}} ^ cbc_chain);
            expected_blocks.push_back(rsp_payload_type'{b[127:64], b[63:0], 5'd16, 1'b1});
         end else begin
            expected_blocks.push_back(
               rsp_payload_type'{b[127:64], b[63:0], 5'd16, p.last_block});
         end
      end else begin
         ct = b;
         b = decipher(b) ^ cbc_chain;
         cbc_chain = ct;
         if (p.last_block) begin
            pad = b[3:0];
            keep = pad ? 16 - pad : 0;
            for (int i = keep; i < 16; i++) b[127-8*i -: 8] = 8'h00;
            expected_blocks.push_back(rsp_payload_type'{b[127:64], b[63:0], 5'(keep), 1'b1});
         end else begin
            expected_blocks.push_back(rsp_payload_type'{b[127:64], b[63:0], 5'd16, 1'b0});
         end
      end
      if (p.last_block) cbc_chain = {iv_hi, iv_lo};
   endfunction

   function automatic void write_register(input logic [2:0] idx, input logic [63:0] v);
      case (idx) inside
         REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
            key_word[idx[1:0]] = v;
            keys_expanded = 1'b0;
         end
         REG_KSIZE: begin
            key_size = v[1:0];
            keys_expanded = 1'b0;
         end
         REG_DIR: decrypt_mode = v[0];
         REG_IVHI: begin
            iv_hi = v;
            cbc_chain[127:64] = v;
         end
         REG_IVLO: begin
            iv_lo = v;
            cbc_chain[63:0] = v;
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         for (int i = 0; i < 4; i++) key_word[i] = '0;
         key_size = KSIZE_128;
         decrypt_mode = 1'b0;
         iv_hi = '0;
         iv_lo = '0;
         cbc_chain = '0;
         keys_expanded = 1'b0;
         mismatches = 0;
         expected_blocks.delete();
      end else begin
         if (psel && penable && pwrite && pready) write_register(paddr[5:3], pwdata);
         if (req_valid && req_ready) predict_block(req_payload);
         if (rsp_valid && rsp_ready) begin
            if (expected_blocks.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result transaction: %h %h count %0d last %0d",
                           rsp_payload.out_hi, rsp_payload.out_lo,
                           rsp_payload.out_count, rsp_payload.out_last);
            end else begin
               want = expected_blocks.pop_front();
               if (rsp_payload.out_hi !== want.out_hi || rsp_payload.out_lo !== want.out_lo ||
                   rsp_payload.out_count !== want.out_count ||
                   rsp_payload.out_last !== want.out_last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display(
                        "mismatch: expected %h %h cnt %0d last %0d, got %h %h cnt %0d last %0d",
                        want.out_hi, want.out_lo, want.out_count, want.out_last,
                        rsp_payload.out_hi, rsp_payload.out_lo,
                        rsp_payload.out_count, rsp_payload.out_last);
               end
            end
         end
      end
      fail_count <= mismatches;
      blocks_owed <= expected_blocks.size();
   end

endmodule

FILE: test/tb_aes_cbc_pkcs7_engine.sv
`timescale 1ns / 1ps

module tb_aes_cbc_pkcs7_engine;
   import aes_cbc_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_payload;
   logic            psel;
   logic            penable;
   logic            pwrite;
   logic [5:0]      paddr;
   logic [63:0]     pwdata;
   logic [63:0]     prdata;
   logic            pready;
   int              fail_count;
   int              blocks_owed;
   int              cycles = 0;
   int              blocks_sent;
   logic            stalls_on;

   aes_cbc_pkcs7_engine dut (.*);

   aes_cbc_pkcs7_checker checker_inst (.*);

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_ready = stalls_on ? ($urandom_range(0, 99) >= 28) : 1'b1;

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic csr_write(input logic [2:0] idx, input logic [63:0] v);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = {idx, 3'b000};
      pwdata = v;
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
                             input logic [4:0] cnt, input logic last);
      if (stalls_on && $urandom_range(0, 99) < 28) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_payload = '{hi, lo, cnt, last};
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      blocks_sent++;
   endtask

   task automatic drain();
      req_valid = 1'b0;
      wait (blocks_owed == 0);
      repeat (300) @(negedge clock);
   endtask

   task automatic configure(input logic [63:0] k0, input logic [63:0] k1, input logic [63:0] k2,
                            input logic [63:0] k3, input logic [1:0] ks, input logic dir,
                            input logic [63:0] ivh, input logic [63:0] ivl);
      csr_write(REG_KEY0, k0);
      csr_write(REG_KEY1, k1);
      csr_write(REG_KEY2, k2);
      csr_write(REG_KEY3, k3);
      csr_write(REG_KSIZE, {62'd0, ks});
      csr_write(REG_DIR, {63'd0, dir});
      csr_write(REG_IVHI, ivh);
      csr_write(REG_IVLO, ivl);
   endtask

   // one message with random content; short counts on non-final blocks are ignored
   task automatic send_message(input int nblocks, input logic decrypting);
      logic [4:0] cnt;
      for (int i = 0; i < nblocks; i++) begin
         if (decrypting || $urandom_range(0, 9) == 0) cnt = 5'($urandom_range(0, 31));
         else if (i == nblocks - 1) cnt = 5'($urandom_range(0, 20));
         else cnt = 5'd16;
         send_block(rand64(), rand64(), cnt, i == nblocks - 1);
      end
   endtask

   initial begin
      logic [63:0] kw [4];
      logic        dir;
      int          phase_start;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      blocks_sent = 0;
      stalls_on = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: all-zero 128-bit key, encrypt, zero iv
      send_block('0, '0, 5'd0, 1'b1);
      send_block('1, '1, 5'd16, 1'b1);
      send_block('1, '0, 5'd31, 1'b1);
      send_block('0, '1, 5'd3, 1'b0);
      send_block('1, '1, 5'd15, 1'b1);
      send_block('1, '0, 5'd1, 1'b1);
      drain();
      // unused key size code behaves as 256 bit; decrypt
      configure('1, '1, '1, '1, 2'd3, 1'b1, '1, '1);
      send_block('0, '0, 5'd16, 1'b0);
      send_block('1, '1, 5'd0, 1'b0);
      send_block('1, '1, 5'd31, 1'b1);
      send_block('0, '0, 5'd5, 1'b1);
      drain();
      configure(rand64(), rand64(), rand64(), rand64(), KSIZE_192, 1'b0, '0, '1);
      send_block(rand64(), rand64(), 5'd16, 1'b0);
      send_block(rand64(), rand64(), 5'd16, 1'b1);
      send_block(rand64(), rand64(), 5'd8, 1'b1);
      drain();
      configure(rand64(), rand64(), rand64(), rand64(), KSIZE_192, 1'b1, rand64(), rand64());
      send_block(rand64(), rand64(), 5'd16, 1'b0);
      send_block(rand64(), rand64(), 5'd16, 1'b1);
      drain();

      for (int phase = 0; phase < 12; phase++) begin
         for (int i = 0; i < 4; i++) kw[i] = rand64();
         if (phase == 1) for (int i = 0; i < 4; i++) kw[i] = '0;
         if (phase == 2) for (int i = 0; i < 4; i++) kw[i] = '1;
         dir = phase[0];
         configure(kw[0], kw[1], kw[2], kw[3], 2'(phase % 4), dir, rand64(), rand64());
         stalls_on = !(phase == 4 || phase == 5);
         phase_start = blocks_sent;
         while (blocks_sent - phase_start < 85) begin
            send_message($urandom_range(1, 8), dir);
            // mid-phase iv change between messages
            if ($urandom_range(0, 15) == 0) begin
               drain();
               csr_write(REG_IVHI, rand64());
               csr_write(REG_IVLO, rand64());
            end
         end
         drain();
      end

      req_valid = 1'b0;
      wait (blocks_owed == 0);
      repeat (300) @(negedge clock);
      if (fail_count == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule
